FILE: sv/tpg_pkg.sv
// Package for the touchpad tap-and-drag gesture block.
// Holds the gesture phase type, register map, phase codes and shared structs.
// Has no dependencies; every other file of the block imports it.
package tpg_pkg;

    // Gesture phases, kept one-hot inside the block.
    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_PMOVE = 6'b000010,
        PH_MOVE  = 6'b000100,
        PH_PHOLD = 6'b001000,
        PH_HOLD  = 6'b010000,
        PH_ABORT = 6'b100000
    } phase_t;

    // Phase codes as reported on the result channel.
    localparam logic [2:0] PC_IDLE  = 3'd0;
    localparam logic [2:0] PC_PMOVE = 3'd1;
    localparam logic [2:0] PC_MOVE  = 3'd2;
    localparam logic [2:0] PC_PHOLD = 3'd3;
    localparam logic [2:0] PC_HOLD  = 3'd4;
    localparam logic [2:0] PC_ABORT = 3'd5;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_MOVE_DELAY  = 2'd0;
    localparam logic [1:0] REG_HOLD_WINDOW = 2'd1;
    localparam logic [1:0] REG_HOLD_LOCK   = 2'd2;

    localparam logic [15:0] MOVE_DELAY_RST  = 16'd100;
    localparam logic [15:0] HOLD_WINDOW_RST = 16'd250;
    localparam logic        HOLD_LOCK_RST   = 1'b1;

    localparam logic [2:0] COUNT_MAX = 3'd7;

    typedef struct packed {
        logic [15:0] move_delay_ms;
        logic [15:0] hold_window_ms;
        logic        hold_lock_enable;
    } cfg_t;

    // Gesture state that does not depend on the number of finger slots.
    typedef struct packed {
        phase_t      phase;
        logic        first_valid;
        logic [31:0] mark_time;
        logic [2:0]  prev_count;
    } gest_state_t;

    typedef struct packed {
        logic [2:0] finger_count;
        logic [2:0] phase_now;
        logic       button_press;
        logic       hold_active;
    } result_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:  code = PC_IDLE;
            PH_PMOVE: code = PC_PMOVE;
            PH_MOVE:  code = PC_MOVE;
            PH_PHOLD: code = PC_PHOLD;
            PH_HOLD:  code = PC_HOLD;
            PH_ABORT: code = PC_ABORT;
            default:  code = PC_IDLE;
        endcase
        return code;
    endfunction

endpackage

FILE: sv/tpg_cfg_regs.sv
// Configuration registers of the gesture block behind an APB-style port.
// Depends on tpg_pkg for the register map, reset values and cfg_t.
// Writes complete in the access cycle; pready is tied high.
module tpg_cfg_regs
    import tpg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                REG_MOVE_DELAY:  cfg_next.move_delay_ms    = pwdata[15:0];
                REG_HOLD_WINDOW: cfg_next.hold_window_ms   = pwdata[15:0];
                REG_HOLD_LOCK:   cfg_next.hold_lock_enable = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.move_delay_ms    <= MOVE_DELAY_RST;
            cfg_reg.hold_window_ms   <= HOLD_WINDOW_RST;
            cfg_reg.hold_lock_enable <= HOLD_LOCK_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MOVE_DELAY:  prdata = {16'd0, cfg_reg.move_delay_ms};
            REG_HOLD_WINDOW: prdata = {16'd0, cfg_reg.hold_window_ms};
            REG_HOLD_LOCK:   prdata = {31'd0, cfg_reg.hold_lock_enable};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

FILE: sv/tpg_step.sv
// Next-state and result logic for one touchpad poll of the gesture block.
// Purely combinational; the top level registers its inputs and outputs.
// Depends on tpg_pkg for phase_t, cfg_t, gest_state_t and result_t.
module tpg_step
    import tpg_pkg::*;
#(
    parameter int FINGERS = 5,
    parameter int IW      = 3
) (
    input  cfg_t              cfg,
    input  logic [FINGERS-1:0] tips,
    input  logic [31:0]       now_ms,
    input  gest_state_t       st_in,
    input  logic [IW-1:0]     first_index_in,
    output gest_state_t       st_out,
    output logic [IW-1:0]     first_index_out,
    output result_t           res
);

    localparam int CW = $clog2(FINGERS + 1);

    logic [CW-1:0]     count_full;
    logic [2:0]        count;
    logic              any_tip;
    logic [IW-1:0]     low_all;
    logic              any_above;
    logic [IW-1:0]     low_above;
    logic              tip_at_first;
    logic              lock_scan;
    logic              lock_idle;
    logic [31:0]       elapsed;
    logic [15:0]       limit;
    logic              timed_out;
    phase_t            ph;
    logic              valid;
    logic [IW-1:0]     idx;
    logic [31:0]       mark;
    logic              button;

    // Finger count, saturated to the 3-bit report field.
    always_comb begin
        count_full = '0;
        for (int i = 0; i < FINGERS; i++) begin
            count_full = count_full + CW'(tips[i]);
        end
        count = (32'(count_full) > 32'd7) ? COUNT_MAX : 3'(count_full);
    end

    // Lowest touching slot overall, and lowest touching slot above the
    // tracked first finger (the scan can pick a new first finger there
    // after the old one lifted).
    always_comb begin
        any_tip      = 1'b0;
        low_all      = '0;
        any_above    = 1'b0;
        low_above    = '0;
        tip_at_first = 1'b0;
        for (int i = FINGERS - 1; i >= 0; i--) begin
            if (tips[i]) begin
                any_tip = 1'b1;
                low_all = IW'(i);
                if (32'(i) > 32'(first_index_in)) begin
                    any_above = 1'b1;
                    low_above = IW'(i);
                end
            end
            if (32'(i) == 32'(first_index_in)) begin
                tip_at_first = tips[i];
            end
        end
    end

    assign lock_scan = cfg.hold_lock_enable && (st_in.phase == PH_HOLD);

    always_comb begin
        ph     = st_in.phase;
        valid  = st_in.first_valid;
        idx    = first_index_in;
        mark   = st_in.mark_time;

        if (!valid) begin
            if (any_tip) begin
                valid = 1'b1;
                idx   = low_all;
                ph    = PH_PMOVE;
                mark  = now_ms;
            end
        end else if (!tip_at_first && !lock_scan) begin
            if (any_above) begin
                idx  = low_above;
                ph   = PH_PMOVE;
                mark = now_ms;
            end else begin
                valid = 1'b0;
                ph    = PH_ABORT;
            end
        end

        lock_idle = cfg.hold_lock_enable && (ph == PH_HOLD);
        if (!lock_idle && count == 3'd0) begin
            ph    = PH_IDLE;
            valid = 1'b0;
        end

        // One subtractor serves both timed phases.
        elapsed   = now_ms - mark;
        limit     = (ph == PH_PMOVE) ? cfg.move_delay_ms : cfg.hold_window_ms;
        timed_out = elapsed > {16'd0, limit};

        button          = 1'b0;
        st_out.prev_count = st_in.prev_count;
        case (ph)
            PH_PMOVE: begin
                if (count != 3'd1) begin
                    ph = PH_ABORT;
                end else if (timed_out) begin
                    ph = PH_MOVE;
                end
            end
            PH_MOVE: begin
                if (count == 3'd2) begin
                    ph   = PH_PHOLD;
                    mark = now_ms;
                end
            end
            PH_PHOLD: begin
                if (count == 3'd1) begin
                    ph     = PH_HOLD;
                    button = 1'b1;
                end else if (timed_out) begin
                    ph = PH_ABORT;
                end
            end
            PH_HOLD: begin
                // A two-finger tap, seen as the count falling to one,
                // releases the drag.
                if (count == 3'd1 && st_in.prev_count > 3'd1) begin
                    ph = PH_MOVE;
                end
                st_out.prev_count = count;
                button = 1'b1;
            end
            default: ;
        endcase

        st_out.phase       = ph;
        st_out.first_valid = valid;
        st_out.mark_time   = mark;
        first_index_out    = idx;

        res.hold_active  = (ph == PH_HOLD);
        res.button_press = button;
        res.phase_now    = phase_code(ph);
        res.finger_count = count;
    end

endmodule

FILE: sv/touchpad_tap_drag_gesture_fsm_core.sv
// Touchpad tap-and-drag gesture machine, top level.
// Instantiates tpg_cfg_regs and tpg_step; depends on tpg_pkg.
//
// Usage: each request on the s_ channel is one touchpad poll (contact mask
// and millisecond time). Every poll yields exactly one result on the m_
// channel with the hold flag, button, gesture phase and finger count.
// A poll is first captured in an input register; the gesture state and the
// result register are updated together when it moves on. One poll per cycle
// is sustained while the receiver does not stall, as the state update
// between the two registers is combinational.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; s_tready falls only when both are full.
// The APB port sets the move delay, hold window and hold lock; write it only
// while no poll is in flight. Synchronous reset (aresetn low) empties both
// registers, restores the register defaults (100 ms, 250 ms, lock on) and
// returns the gesture to idle with no first finger tracked.
module touchpad_tap_drag_gesture_fsm_core
    import tpg_pkg::*;
#(
    parameter int FINGERS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [FINGERS-1:0] contact_tips, [FINGERS+31:FINGERS] now_ms, zero pad
    input  logic [((FINGERS+32+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] hold_active, [1] button_press, [4:2] phase_now, [7:5] finger_count
    output logic [7:0]  m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (FINGERS > 1) ? $clog2(FINGERS) : 1;

    cfg_t               cfg;
    logic               in_valid_reg;
    logic [FINGERS-1:0] in_tips_reg;
    logic [31:0]        in_now_reg;
    logic               out_valid_reg;
    result_t            out_res_reg;
    gest_state_t        st_reg;
    gest_state_t        st_next;
    logic [IW-1:0]      first_index_reg;
    logic [IW-1:0]      first_index_next;
    result_t            res_next;
    logic               advance;
    logic               s_acc;

    tpg_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tpg_step #(
        .FINGERS (FINGERS),
        .IW      (IW)
    ) u_step (
        .cfg             (cfg),
        .tips            (in_tips_reg),
        .now_ms          (in_now_reg),
        .st_in           (st_reg),
        .first_index_in  (first_index_reg),
        .st_out          (st_next),
        .first_index_out (first_index_next),
        .res             (res_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_acc) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_tips_reg <= s_tdata[FINGERS-1:0];
            in_now_reg  <= s_tdata[FINGERS+31:FINGERS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase       <= PH_IDLE;
            st_reg.first_valid <= 1'b0;
            st_reg.mark_time   <= 32'd0;
            st_reg.prev_count  <= 3'd0;
            first_index_reg    <= '0;
        end else if (advance) begin
            st_reg          <= st_next;
            first_index_reg <= first_index_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

`ifndef SYNTHESIS
    a_pmove_tracks_finger: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.phase == PH_PMOVE) |-> st_reg.first_valid)
        else $error("possible move without a tracked first finger");

    a_idle_no_finger: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.phase == PH_IDLE) |-> !st_reg.first_valid)
        else $error("idle phase with a tracked first finger");

    a_hold_has_button: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.hold_active) |-> out_res_reg.button_press)
        else $error("hold reported without the button");

    a_state_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(st_reg))
        else $error("gesture state changed without a request moving on");
`endif

endmodule
